@@ sv/vdu_pkg.sv @@
// ----------------------------------------------------------------------------
// vdu_pkg
// shared types and constants of the vector distance unit
// ----------------------------------------------------------------------------
package vdu_pkg;

  localparam int DIST_WIDTH = 32;
  localparam int WIDE_WIDTH = 64;

  typedef enum logic {
    METRIC_EUCLIDEAN = 1'b0,
    METRIC_MANHATTAN = 1'b1
  } metric_t;

  // back end to root unit
  typedef struct packed {
    logic start;
    logic ack;
  } sqrt_ctl_t;

  // root unit to back end
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_sts_t;

endpackage

@@ sv/vdu_if.sv @@
// ----------------------------------------------------------------------------
// vdu interfaces
// valid/ready channels for coordinate items, results and the mode register
// ----------------------------------------------------------------------------
interface vdu_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_a;
  logic signed [COORD_WIDTH-1:0] coord_b;
  logic                          last_dim;

  modport source(output valid, output coord_a, output coord_b, output last_dim,
                 input ready);
  modport sink(input valid, input coord_a, input coord_b, input last_dim,
               output ready);
endinterface

interface vdu_out_if;
  import vdu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [DIST_WIDTH-1:0] distance;
  logic                  saturated;

  modport source(output valid, output distance, output saturated, input ready);
  modport sink(input valid, input distance, input saturated, output ready);
endinterface

interface vdu_cfg_if;
  logic valid;
  logic ready;
  logic metric_mode;

  modport source(output valid, output metric_mode, input ready);
  modport sink(input valid, input metric_mode, output ready);
endinterface

@@ sv/vector_distance_unit_core.sv @@
// result path: a manhattan result passes the queue, the term register and the output
// register; a euclidean result also passes the root unit before the output register
// throughput: one item per cycle while the queue is not full; a euclidean last item holds
// the root unit until its root moves to the output register, and the next last item waits
// for it behind a 4-entry queue; reset: synchronous active-low rst_n clears the sum,
// overflow flag, queue, root unit and output valid and holds both ready low; metric_mode resets to euclidean
// ----------------------------------------------------------------------------
// vector_distance_unit_core
// streaming euclidean / manhattan distance between two fixed-point points
// ----------------------------------------------------------------------------
module vector_distance_unit_core #(
  parameter int COORD_WIDTH = 16,
  parameter int SUM_WIDTH   = 48
) (
  input  logic      clk,
  input  logic      rst_n,
  vdu_in_if.sink    in_ch,
  vdu_out_if.source out_ch,
  vdu_cfg_if.sink   cfg_ch
);
  import vdu_pkg::*;

  localparam int QW    = COORD_WIDTH + 4;
  localparam int QDEPTH = 4;

  metric_t       mode_r;
  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;
  logic          in_hold;

  // no transaction is taken while in reset
  assign cfg_ch.ready = rst_n;
  assign in_hold      = q_full || !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= METRIC_EUCLIDEAN;
    end else if (cfg_ch.valid) begin
      mode_r <= metric_t'(cfg_ch.metric_mode);
    end
  end

  vdu_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .in_ch (in_ch),
    .mode  (mode_r),
    .q_full(in_hold),
    .q_push(q_push),
    .q_data(q_wdata)
  );

  vdu_fifo #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .full     (q_full),
    .empty    (q_empty)
  );

  vdu_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_data (q_rdata),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

@@ sv/vdu_front.sv @@
// ----------------------------------------------------------------------------
// vdu_front
// accepts coordinate pairs, forms |a-b| and tags each with mode and last flag
// ----------------------------------------------------------------------------
module vdu_front #(
  parameter int COORD_WIDTH = 16
) (
  vdu_in_if.sink                   in_ch,
  input  vdu_pkg::metric_t         mode,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [COORD_WIDTH+3:0]   q_data
);
  import vdu_pkg::*;

  localparam int MW = COORD_WIDTH + 1;

  logic signed [MW-1:0] diff;
  logic        [MW-1:0] mag;
  logic                 too_big;

  assign diff = MW'(in_ch.coord_a) - MW'(in_ch.coord_b);
  assign mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);

  // a magnitude past 32 bits cannot be squared into the sum
  assign too_big = (mode == METRIC_EUCLIDEAN) && ((mag >> DIST_WIDTH) != '0);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign q_data      = {mode == METRIC_MANHATTAN, in_ch.last_dim, too_big, mag};

endmodule

@@ sv/vdu_fifo.sv @@
// ----------------------------------------------------------------------------
// vdu_fifo
// short register queue between front and back end
// ----------------------------------------------------------------------------
module vdu_fifo #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      count_r;
  logic [PW:0]      count_nxt;

  assign full     = (count_r == (PW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/vdu_isqrt.sv @@
// ----------------------------------------------------------------------------
// vdu_isqrt
// floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module vdu_isqrt #(
  parameter int SUM_WIDTH = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vdu_pkg::sqrt_ctl_t         ctl,
  input  logic [SUM_WIDTH-1:0]       operand,
  output vdu_pkg::sqrt_sts_t         sts,
  output logic [(SUM_WIDTH+1)/2-1:0] root
);
  import vdu_pkg::*;

  localparam int RW = (SUM_WIDTH + 1) / 2;
  localparam int CW = $clog2(RW + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t          state_r;
  logic [2*RW-1:0] x_r;
  logic [RW:0]     rem_r;
  logic [RW-1:0]   root_r;
  logic [CW-1:0]   cnt_r;

  logic [RW+2:0]   rem_sh;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   rem_dif;
  logic            take;

  assign rem_sh  = {rem_r, x_r[2*RW-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign rem_dif = rem_sh - trial;
  assign take    = (rem_sh >= trial);

  assign sts.busy = (state_r == S_RUN);
  assign sts.done = (state_r == S_DONE);
  assign root     = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctl.start) begin
            x_r     <= (2*RW)'(operand);
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= CW'(RW);
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          rem_r  <= take ? rem_dif[RW:0] : rem_sh[RW:0];
          root_r <= {root_r[RW-2:0], take};
          x_r    <= {x_r[2*RW-3:0], 2'b00};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (ctl.ack) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/vdu_back.sv @@
// ----------------------------------------------------------------------------
// vdu_back
// squares or passes terms, keeps the saturating sum, forms the result
// ----------------------------------------------------------------------------
module vdu_back #(
  parameter int COORD_WIDTH = 16,
  parameter int SUM_WIDTH   = 48
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [COORD_WIDTH+3:0] q_data,
  input  logic                   q_empty,
  output logic                   q_pop,
  vdu_out_if.source              out_ch
);
  import vdu_pkg::*;

  localparam int MW = COORD_WIDTH + 1;
  localparam int TW = 2 * MW;
  localparam int AW = ((TW > SUM_WIDTH) ? TW : SUM_WIDTH) + 1;
  localparam int RW = (SUM_WIDTH + 1) / 2;

  // queue entry fields
  logic [MW-1:0] e_mag;
  logic          e_big;
  logic          e_last;
  logic          e_manh;
  assign {e_manh, e_last, e_big, e_mag} = q_data;

  // term stage
  logic          a_valid_r;
  logic [TW-1:0] a_term_r;
  logic          a_big_r;
  logic          a_last_r;
  logic          a_manh_r;
  logic [TW-1:0] sq;
  logic [TW-1:0] a_term_nxt;

  // accumulate stage
  logic [SUM_WIDTH-1:0] sum_r;
  logic                 ovf_r;
  logic                 sat_pend_r;
  logic [AW-1:0]        add;
  logic                 over;
  logic [SUM_WIDTH-1:0] sum_nxt;
  logic                 ovf_nxt;
  logic [WIDE_WIDTH-1:0] sum_wide;
  logic                 clamp;

  // output register
  logic                  out_valid_r;
  logic [DIST_WIDTH-1:0] out_dist_r;
  logic                  out_sat_r;
  logic                  out_free;

  sqrt_ctl_t     sq_ctl;
  sqrt_sts_t     sq_sts;
  logic [RW-1:0] sq_root;
  logic          sq_active;

  logic b_take;
  logic a_adv;
  logic emit_manh;

  assign sq         = e_mag * e_mag;
  assign a_term_nxt = e_manh ? TW'(e_mag) : sq;

  assign add     = AW'(sum_r) + AW'(a_term_r);
  assign over    = a_big_r || (add[AW-1:SUM_WIDTH] != '0);
  assign sum_nxt = over ? {SUM_WIDTH{1'b1}} : add[SUM_WIDTH-1:0];
  assign ovf_nxt = ovf_r || over;

  assign sum_wide = WIDE_WIDTH'(sum_nxt);
  assign clamp    = (sum_wide[WIDE_WIDTH-1:DIST_WIDTH] != '0);

  assign out_free  = !out_valid_r || out_ch.ready;
  assign sq_active = sq_sts.busy || sq_sts.done;

  // a last item waits for the root unit, and a manhattan one for the output
  assign b_take    = a_valid_r && (!a_last_r ||
                     (!sq_active && (!a_manh_r || out_free)));
  assign emit_manh = b_take && a_last_r && a_manh_r;
  assign a_adv     = !a_valid_r || b_take;
  assign q_pop     = a_adv && !q_empty;

  assign sq_ctl.start = b_take && a_last_r && !a_manh_r;
  assign sq_ctl.ack   = sq_sts.done && out_free;

  vdu_isqrt #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sq_ctl),
    .operand(sum_nxt),
    .sts    (sq_sts),
    .root   (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_r <= !q_empty;
      end
      if (b_take) begin
        if (a_last_r) begin
          sum_r <= '0;
          ovf_r <= 1'b0;
        end else begin
          sum_r <= sum_nxt;
          ovf_r <= ovf_nxt;
        end
      end
      if (emit_manh || sq_ctl.ack) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_term_r <= a_term_nxt;
      a_big_r  <= e_big;
      a_last_r <= e_last;
      a_manh_r <= e_manh;
    end
    if (sq_ctl.start) begin
      sat_pend_r <= ovf_nxt;
    end
    if (emit_manh) begin
      out_dist_r <= clamp ? '1 : sum_wide[DIST_WIDTH-1:0];
      out_sat_r  <= ovf_nxt || clamp;
    end else if (sq_ctl.ack) begin
      out_dist_r <= DIST_WIDTH'(sq_root);
      out_sat_r  <= sat_pend_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.distance  = out_dist_r;
  assign out_ch.saturated = out_sat_r;

endmodule

@@ sv/vdu_checker.sv @@
// ----------------------------------------------------------------------------
// vdu_checker
// port-level checks of the vector distance unit, bound to the top level
// ----------------------------------------------------------------------------
module vdu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_distance,
  input logic        out_saturated
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) &&
    $stable(out_saturated))
    else $error("result changed while stalled");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a result forms only after reset, through queue, term and output register
  a_min_latency: assert property (@(posedge clk)
    $rose(out_valid) |-> $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3))
    else $error("result appeared too soon after reset");

  // the block takes no items during reset cycles it then discards
  a_no_accept_in_reset: assert property (@(posedge clk)
    !rst_n |-> !(in_valid && in_ready))
    else $error("input transaction accepted during reset");

endmodule

bind vector_distance_unit_core vdu_checker u_vdu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_distance (out_ch.distance),
  .out_saturated(out_ch.saturated)
);
